@@ src/dsuf_pkg.sv @@
package dsuf_pkg;

    localparam int IDX_W    = 10;
    localparam int CNT_W    = 11;
    localparam int RANK_W   = 4;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    localparam logic [RANK_W-1:0] RANK_MAX   = 4'd15;
    localparam logic              ACT_UNION  = 1'b0;
    localparam logic              ACT_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT_RD,
        S_ROOT_CHK,
        S_CMP_RD,
        S_CMP_WR,
        S_LINK_X,
        S_LINK_Y,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        P_FIND_A,
        P_FIND_B,
        P_REFIND_A,
        P_REFIND_B
    } phase_t;

endpackage

@@ src/dsuf_ram.sv @@
module dsuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/disjoint_set_union_find.sv @@
// Union-find engine with union by rank and path compression over a single-port-read,
// single-port-write table of {size, rank, parent} words. Each transaction runs alone:
// a range check, a find of each element, an optional link of the roots in S_LINK_X and
// S_LINK_Y, and a second find of each element for the result. Every find reads up the
// parent chain to the root, then repoints each entry on that path at the root; the
// table read is registered. An index error skips the finds and goes straight to the
// result. After reset and after every element_count write the table is swept over all
// MAX_ELEMENTS entries, during which s_tready stays low.
module disjoint_set_union_find
    import dsuf_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // first_index, second_index
    input  logic                s_tuser,  // action
    output logic                m_tvalid,
    input  logic                m_tready,
    // first_root, second_root, same_set, first_set_size, set_count, merged, index_error
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CLR_W = AW + 1;
    localparam int EW    = CNT_W + RANK_W + AW;
    localparam int RST_CNT = (MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [AW-1:0]       a_reg, a_next, b_reg, b_next;
    logic                act_reg, act_next;
    logic                err_reg, err_next;
    logic                merged_reg, merged_next;
    logic [AW-1:0]       cur_reg, cur_next, walk_reg, walk_next, root_reg, root_next;
    logic [AW-1:0]       x_reg, x_next, y_reg, y_next, ra_reg, ra_next;
    logic [EW-1:0]       rw_reg, rw_next, xw_reg, xw_next, yw_reg, yw_next;
    logic [CNT_W-1:0]    size_reg, size_next;
    logic [CNT_W-1:0]    ec_reg, ec_next, sets_reg, sets_next;
    logic [CLR_W-1:0]    clr_reg, clr_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [EW-1:0]       ram_wdata, ram_rdata;

    logic [AW-1:0]       rd_parent, node;
    logic [RANK_W-1:0]   xrank, yrank, hrank;
    logic [CNT_W-1:0]    cfg_cnt;
    logic [IDX_W-1:0]    in_first, in_second;

    dsuf_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_ELEMENTS)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_parent = ram_rdata[AW-1:0];
    assign node      = (phase_reg == P_FIND_A || phase_reg == P_REFIND_A) ? a_reg : b_reg;
    assign xrank     = xw_reg[AW +: RANK_W];
    assign yrank     = yw_reg[AW +: RANK_W];
    assign in_first  = s_tdata[IDX_W-1:0];
    assign in_second = s_tdata[2*IDX_W-1:IDX_W];

    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_cnt = CNT_W'(1);
        end else if (32'(cfg_wr_data) > RST_CNT) begin
            cfg_cnt = CNT_W'(RST_CNT);
        end else begin
            cfg_cnt = cfg_wr_data;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        act_next     = act_reg;
        err_next     = err_reg;
        merged_next  = merged_reg;
        cur_next     = cur_reg;
        walk_next    = walk_reg;
        root_next    = root_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        ra_next      = ra_reg;
        rw_next      = rw_reg;
        xw_next      = xw_reg;
        yw_next      = yw_reg;
        size_next    = size_reg;
        ec_next      = ec_reg;
        sets_next    = sets_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;
        hrank        = yrank;

        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg[AW-1:0];
                ram_wdata = {CNT_W'(1), RANK_W'(0), clr_reg[AW-1:0]};
                clr_next  = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_W'(MAX_ELEMENTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    a_next      = AW'(in_first);
                    b_next      = AW'(in_second);
                    act_next    = s_tuser;
                    merged_next = 1'b0;
                    phase_next  = P_FIND_A;
                    cur_next    = AW'(in_first);
                    if (CNT_W'(in_first) >= ec_reg || CNT_W'(in_second) >= ec_reg) begin
                        err_next   = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        err_next   = 1'b0;
                        state_next = S_ROOT_RD;
                    end
                end
            end
            S_ROOT_RD: begin
                ram_raddr  = cur_reg;
                state_next = S_ROOT_CHK;
            end
            S_ROOT_CHK: begin
                if (rd_parent == cur_reg) begin
                    root_next  = cur_reg;
                    rw_next    = ram_rdata;
                    walk_next  = node;
                    state_next = S_CMP_RD;
                end else begin
                    cur_next   = rd_parent;
                    state_next = S_ROOT_RD;
                end
            end
            S_CMP_RD: begin
                if (walk_reg == root_reg) begin
                    case (phase_reg)
                        P_FIND_A: begin
                            x_next     = root_reg;
                            xw_next    = rw_reg;
                            phase_next = P_FIND_B;
                            cur_next   = b_reg;
                            state_next = S_ROOT_RD;
                        end
                        P_FIND_B: begin
                            y_next  = root_reg;
                            yw_next = rw_reg;
                            if (act_reg == ACT_UNION && x_reg != root_reg) begin
                                state_next = S_LINK_X;
                            end else begin
                                phase_next = P_REFIND_A;
                                cur_next   = a_reg;
                                state_next = S_ROOT_RD;
                            end
                        end
                        P_REFIND_A: begin
                            ra_next    = root_reg;
                            size_next  = rw_reg[AW+RANK_W +: CNT_W];
                            phase_next = P_REFIND_B;
                            cur_next   = b_reg;
                            state_next = S_ROOT_RD;
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end else begin
                    ram_raddr  = walk_reg;
                    state_next = S_CMP_WR;
                end
            end
            S_CMP_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = walk_reg;
                ram_wdata  = {ram_rdata[EW-1:AW], root_reg};
                walk_next  = rd_parent;
                state_next = S_CMP_RD;
            end
            S_LINK_X: begin
                ram_we      = 1'b1;
                merged_next = 1'b1;
                if (sets_reg > CNT_W'(1)) begin
                    sets_next = sets_reg - CNT_W'(1);
                end
                if (xrank > yrank) begin
                    ram_waddr = y_reg;
                    ram_wdata = {yw_reg[EW-1:AW], x_reg};
                    x_next    = y_reg;
                    y_next    = x_reg;
                    xw_next   = yw_reg;
                    yw_next   = xw_reg;
                end else begin
                    ram_waddr = x_reg;
                    ram_wdata = {xw_reg[EW-1:AW], y_reg};
                end
                state_next = S_LINK_Y;
            end
            S_LINK_Y: begin
                if (xrank == yrank && yrank < RANK_MAX) begin
                    hrank = yrank + RANK_W'(1);
                end
                ram_we     = 1'b1;
                ram_waddr  = y_reg;
                ram_wdata  = {yw_reg[AW+RANK_W +: CNT_W] + xw_reg[AW+RANK_W +: CNT_W],
                              hrank, y_reg};
                phase_next = P_REFIND_A;
                cur_next   = a_reg;
                state_next = S_ROOT_RD;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    if (err_reg) begin
                        m_data_next = {3'b000, 1'b1, 1'b0, sets_reg, CNT_W'(0), 1'b0,
                                       IDX_W'(0), IDX_W'(0)};
                    end else begin
                        m_data_next = {3'b000, 1'b0, merged_reg, sets_reg, size_reg,
                                       (ra_reg == root_reg), IDX_W'(root_reg),
                                       IDX_W'(ra_reg)};
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            ec_next    = cfg_cnt;
            sets_next  = cfg_cnt;
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            phase_reg   <= P_FIND_A;
            clr_reg     <= '0;
            ec_reg      <= CNT_W'(RST_CNT);
            sets_reg    <= CNT_W'(RST_CNT);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            clr_reg     <= clr_next;
            ec_reg      <= ec_next;
            sets_reg    <= sets_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        act_reg    <= act_next;
        err_reg    <= err_next;
        merged_reg <= merged_next;
        cur_reg    <= cur_next;
        walk_reg   <= walk_next;
        root_reg   <= root_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        ra_reg     <= ra_next;
        rw_reg     <= rw_next;
        xw_reg     <= xw_next;
        yw_reg     <= yw_next;
        size_reg   <= size_next;
        m_data_reg <= m_data_next;
    end

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_tready)
        else $error("input accepted during table sweep");

    a_sets_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        sets_reg <= ec_reg)
        else $error("set count above element count");

    a_merged_joins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[43] |-> m_data_reg[20] && !m_data_reg[44])
        else $error("merge reported without a common root");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[44] |-> m_data_reg[31:0] == '0 && !m_data_reg[43])
        else $error("index error result carries data");

endmodule

@@ tb/disjoint_set_union_find_tb.sv @@
module disjoint_set_union_find_tb;
    import dsuf_pkg::*;

    localparam int NUM_ELEM    = 1024;
    localparam int RANDOM_OPS  = 360;
    localparam int IDLE_LIMIT  = 40000;

    typedef struct packed {
        logic              index_error;
        logic              merged;
        logic [CNT_W-1:0]  set_count;
        logic [CNT_W-1:0]  first_set_size;
        logic              same_set;
        logic [IDX_W-1:0]  second_root;
        logic [IDX_W-1:0]  first_root;
    } answer_t;

    typedef struct {
        logic             act;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic             known;
        answer_t          ans;
    } op_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    logic [IDX_W-1:0]  dsu_parent [NUM_ELEM];
    logic [RANK_W-1:0] dsu_rank [NUM_ELEM];
    logic [CNT_W-1:0]  dsu_size [NUM_ELEM];
    logic [CNT_W-1:0]  dsu_sets;
    int unsigned       dsu_elems;

    answer_t pending_answers [$];
    int      error_count = 0;
    int      idle_cycles = 0;
    bit      stall_mode = 1'b1;
    op_row_t directed_ops [$];

    disjoint_set_union_find #(.MAX_ELEMENTS(NUM_ELEM)) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #4 aclk = ~aclk;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void dsu_clear(input int unsigned count);
        dsu_elems = (count < 1) ? 1 : (count > NUM_ELEM) ? NUM_ELEM : count;
        for (int i = 0; i < NUM_ELEM; i++) begin
            dsu_parent[i] = IDX_W'(i);
            dsu_rank[i] = '0;
            dsu_size[i] = CNT_W'(1);
        end
        dsu_sets = CNT_W'(dsu_elems);
    endfunction

    function automatic int dsu_find(input int node);
        int root;
        int walk;
        int up;
        root = node;
        while (dsu_parent[root] != root) root = dsu_parent[root];
        walk = node;
        while (walk != root) begin
            up = dsu_parent[walk];
            dsu_parent[walk] = IDX_W'(root);
            walk = up;
        end
        return root;
    endfunction

    function automatic answer_t dsu_apply(input logic act, input int a, input int b);
        answer_t r;
        int x, y, t;
        r = '0;
        if (a >= dsu_elems || b >= dsu_elems) begin
            r.set_count = dsu_sets;
            r.index_error = 1'b1;
            return r;
        end
        x = dsu_find(a);
        y = dsu_find(b);
        if (act == ACT_UNION && x != y) begin
            if (dsu_rank[x] > dsu_rank[y]) begin
                t = x;
                x = y;
                y = t;
            end
            dsu_parent[x] = IDX_W'(y);
            if (dsu_rank[x] == dsu_rank[y] && dsu_rank[y] < RANK_MAX) dsu_rank[y]++;
            dsu_size[y] = dsu_size[y] + dsu_size[x];
            if (dsu_sets > 1) dsu_sets--;
            r.merged = 1'b1;
        end
        x = dsu_find(a);
        y = dsu_find(b);
        r.first_root = IDX_W'(x);
        r.second_root = IDX_W'(y);
        r.same_set = (x == y);
        r.first_set_size = dsu_size[x];
        r.set_count = dsu_sets;
        return r;
    endfunction

    task automatic wait_cycles(input int n);
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        wait_cycles(200);
    endtask

    task automatic write_elements(input logic [CNT_W-1:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        dsu_clear(value);
    endtask

    task automatic send_op(input logic act, input logic [IDX_W-1:0] a,
                           input logic [IDX_W-1:0] b, input logic known,
                           input answer_t ans);
        answer_t predicted;
        int idle;
        idle = stall_mode ? $urandom_range(0, 12) : 0;
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            wait_cycles(idle);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {4'b0, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = dsu_apply(act, a, b);
        if (known && predicted != ans)
            report($sformatf("typed answer %h disagrees with prediction %h", ans, predicted));
        if (known) predicted = ans;
        pending_answers = {pending_answers, predicted};
    endtask

    function automatic void add_row(input logic act, input int a, input int b,
                                    input logic known = 1'b0, input answer_t ans = '0);
        op_row_t row;
        row.act = act;
        row.a = IDX_W'(a);
        row.b = IDX_W'(b);
        row.known = known;
        row.ans = ans;
        directed_ops = {directed_ops, row};
    endfunction

    function automatic answer_t fresh(input int a, input int b, input int sets);
        answer_t r;
        r = '0;
        r.first_root = IDX_W'(a);
        r.second_root = IDX_W'(b);
        r.same_set = (a == b);
        r.first_set_size = CNT_W'(1);
        r.set_count = CNT_W'(sets);
        return r;
    endfunction

    function automatic answer_t range_fault(input int sets);
        answer_t r;
        r = '0;
        r.set_count = CNT_W'(sets);
        r.index_error = 1'b1;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_answers.size() == 0) begin
                    report($sformatf("unexpected result %h", m_tdata));
                end else begin
                    answer_t got, want;
                    got = answer_t'(m_tdata[$bits(answer_t)-1:0]);
                    want = pending_answers.pop_front();
                    if (got.first_root != want.first_root)
                        report($sformatf("first_root %0d exp %0d", got.first_root,
                            want.first_root));
                    if (got.second_root != want.second_root)
                        report($sformatf("second_root %0d exp %0d", got.second_root,
                            want.second_root));
                    if (got.same_set != want.same_set)
                        report($sformatf("same_set %0b exp %0b", got.same_set, want.same_set));
                    if (got.first_set_size != want.first_set_size)
                        report($sformatf("first_set_size %0d exp %0d", got.first_set_size,
                            want.first_set_size));
                    if (got.set_count != want.set_count)
                        report($sformatf("set_count %0d exp %0d", got.set_count,
                            want.set_count));
                    if (got.merged != want.merged)
                        report($sformatf("merged %0b exp %0b", got.merged, want.merged));
                    if (got.index_error != want.index_error)
                        report($sformatf("index_error %0b exp %0b", got.index_error,
                            want.index_error));
                end
            end
        end
    end

    initial begin
        int wait_left;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                wait_left = stall_mode ? $urandom_range(0, 12) : 0;
                m_tready <= (wait_left == 0);
            end else if (!m_tready) begin
                if (wait_left > 0) wait_left--;
                m_tready <= (wait_left == 0);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int n, a, b, hub;
        logic act;
        dsu_clear(NUM_ELEM);
        wait_cycles(2);
        aresetn <= 1'b1;

        add_row(ACT_QUERY, 0, 1023, 1'b1, fresh(0, 1023, 1024));
        add_row(ACT_QUERY, 5, 5, 1'b1, fresh(5, 5, 1024));
        add_row(ACT_UNION, 0, 1023);
        add_row(ACT_UNION, 1023, 0);
        add_row(ACT_UNION, 682, 341);
        add_row(ACT_UNION, 341, 0);
        add_row(ACT_QUERY, 682, 1023);
        add_row(ACT_UNION, 7, 7);
        add_row(ACT_UNION, 1, 2);
        add_row(ACT_UNION, 3, 4);
        add_row(ACT_UNION, 2, 4);
        add_row(ACT_UNION, 4, 1023);
        add_row(ACT_QUERY, 1, 682);
        foreach (directed_ops[i])
            send_op(directed_ops[i].act, directed_ops[i].a, directed_ops[i].b,
                    directed_ops[i].known, directed_ops[i].ans);

        directed_ops.delete();
        write_elements(CNT_W'(0));
        add_row(ACT_QUERY, 0, 0, 1'b1, fresh(0, 0, 1));
        add_row(ACT_UNION, 0, 1, 1'b1, range_fault(1));
        add_row(ACT_UNION, 1023, 0, 1'b1, range_fault(1));
        foreach (directed_ops[i])
            send_op(directed_ops[i].act, directed_ops[i].a, directed_ops[i].b,
                    directed_ops[i].known, directed_ops[i].ans);

        write_elements(CNT_W'(2047));
        send_op(ACT_QUERY, IDX_W'(1023), IDX_W'(1023), 1'b1, fresh(1023, 1023, 1024));

        // drive ranks up to 10 with a binary merge tree over 1024 elements, short of RANK_MAX
        stall_mode = 1'b0;
        for (int s = 1; s < NUM_ELEM; s = s * 2)
            for (int i = 0; i + s < NUM_ELEM; i += 2 * s)
                send_op(ACT_UNION, IDX_W'(i), IDX_W'(i + s), 1'b0, '0);
        stall_mode = 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: n = 16;
                1: n = 1024;
                2: n = 2;
                default: n = $urandom_range(3, 200);
            endcase
            write_elements(CNT_W'(n));
            if (ph == 1) stall_mode = 1'b0;
            if (ph == 2) stall_mode = 1'b1;
            hub = $urandom_range(0, n - 1);
            for (int k = 0; k < RANDOM_OPS / 4; k++) begin
                if (k == RANDOM_OPS / 8) drain();
                act = ($urandom_range(0, 9) < 6) ? ACT_UNION : ACT_QUERY;
                if ($urandom_range(0, 19) == 0) begin
                    a = $urandom_range(0, 1023);
                    b = $urandom_range(0, 1023);
                end else begin
                    a = $urandom_range(0, n - 1);
                    b = ($urandom_range(0, 3) == 0) ? hub : $urandom_range(0, n - 1);
                end
                send_op(act, IDX_W'(a), IDX_W'(b), 1'b0, '0);
            end
        end

        drain();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
